### rtl/dlst_pkg.sv
`default_nettype none
package dlst_pkg;

  localparam int unsigned MaxTasks  = 16;
  localparam int unsigned TickWidth = 32;
  localparam int unsigned IdW       = 4;
  localparam int unsigned LinkW     = IdW + 1;
  localparam int unsigned QDepth    = 2;

  localparam logic [LinkW-1:0] NilLink = LinkW'(MaxTasks);

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ADD_IGN = 2'd1,
    ST_REM_IGN = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  // Classified command passed from the front end to the execution unit.
  typedef struct packed {
    req_e                 req;
    logic [IdW-1:0]       id;
    logic [TickWidth-1:0] delay;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/dlst_front.sv
`default_nettype none
module dlst_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [1:0]      req_type_i,
  input  wire logic [3:0]      task_id_i,
  input  wire logic [31:0]     delay_ticks_i,
  output logic                 busy_o,
  output logic                 q_valid_o,
  output dlst_pkg::cmd_t       q_cmd_o,
  input  wire logic            q_pop_i
);

  // Two-entry command queue; reserved request codes are dropped here.
  dlst_pkg::cmd_t mem_q [dlst_pkg::QDepth];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, keep;

  assign busy_o    = (cnt_q == 2'(dlst_pkg::QDepth));
  assign push      = start_i && !busy_o;
  assign keep      = push && (req_type_i != dlst_pkg::REQ_NONE);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q + 1'(keep);
    rp_d  = rp_q + 1'(q_pop_i);
    cnt_d = cnt_q + 2'(keep) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      mem_q[wp_q] <= '{req: dlst_pkg::req_e'(req_type_i), id: task_id_i, delay: delay_ticks_i};
    end
  end

endmodule
`default_nettype wire

### rtl/dlst_back.sv
`default_nettype none
module dlst_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire dlst_pkg::cmd_t  q_cmd_i,
  output logic                 q_pop_o,
  output logic                 res_valid_o,
  output logic [3:0]           task_out_o,
  output logic                 expired_o,
  output logic [1:0]           status_o,
  output logic                 last_o
);

  localparam int unsigned N  = dlst_pkg::MaxTasks;
  localparam int unsigned W  = dlst_pkg::TickWidth;
  localparam int unsigned IW = dlst_pkg::IdW;
  localparam int unsigned LW = dlst_pkg::LinkW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_LINK = 5'b00100,
    S_REM  = 5'b01000,
    S_EXP  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [W-1:0]    delta_q [N];
  logic [LW-1:0]   next_q  [N];
  logic [LW-1:0]   prev_q  [N];
  logic [N-1:0]    sleep_q;
  logic [LW-1:0]   head_q;
  dlst_pkg::cmd_t  cmd_q;
  logic [W-1:0]    rem_q;
  logic [LW-1:0]   cur_q, bef_q;
  logic [IW:0]     guard_q, cnt_q;

  logic            rv_q, exp_q, last_q;
  logic [IW-1:0]   tout_q;
  logic [1:0]      st_q;

  logic [IW-1:0]   cur_i, head_i, id;
  logic [W-1:0]    cur_delta, head_delta;
  logic [W:0]      sum;
  logic [LW-1:0]   head_nx;
  logic            exp_go, exp_last;

  assign id         = cmd_q.id;
  assign cur_i      = cur_q[IW-1:0];
  assign head_i     = head_q[IW-1:0];
  assign cur_delta  = delta_q[cur_i];
  assign head_delta = delta_q[head_i];
  assign sum        = {1'b0, delta_q[next_q[id][IW-1:0]]} + {1'b0, delta_q[id]};
  assign q_pop_o    = (state_q == S_IDLE) && q_valid_i;

  // head expires now; it is the last one if the drain stops right after it
  assign head_nx  = next_q[head_i];
  assign exp_go   = !head_q[IW] && head_delta == '0 && cnt_q != (IW+1)'(N);
  assign exp_last = (cnt_q == (IW+1)'(N-1)) || head_nx[IW]
                    || (delta_q[head_nx[IW-1:0]] != '0);

  assign res_valid_o = rv_q;
  assign task_out_o  = tout_q;
  assign expired_o   = exp_q;
  assign status_o    = st_q;
  assign last_o      = last_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (q_valid_i) begin
        unique case (q_cmd_i.req)
          dlst_pkg::REQ_TICK:   state_d = S_EXP;
          dlst_pkg::REQ_ADD:    state_d = S_WALK;
          dlst_pkg::REQ_REMOVE: state_d = S_REM;
          default:              state_d = S_IDLE;
        endcase
      end
      S_WALK: begin
        if (sleep_q[id]) state_d = S_IDLE;
        else if (cur_q[IW] || guard_q == (IW+1)'(N) || cur_delta > rem_q) state_d = S_LINK;
      end
      S_LINK, S_REM: state_d = S_IDLE;
      S_EXP: if (!exp_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sleep_q <= '0;
      head_q  <= dlst_pkg::NilLink;
      rv_q    <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= 1'b0;
      last_q  <= 1'b0;
      unique case (state_q)
        S_WALK: if (sleep_q[id]) begin
          rv_q <= 1'b1; last_q <= 1'b1;
        end
        S_LINK: begin
          sleep_q[id] <= 1'b1;
          if (bef_q[IW]) head_q <= LW'(id);
          rv_q <= 1'b1; last_q <= 1'b1;
        end
        S_REM: begin
          rv_q <= 1'b1; last_q <= 1'b1;
          if (sleep_q[id]) begin
            sleep_q[id] <= 1'b0;
            if (prev_q[id][IW]) head_q <= next_q[id];
          end
        end
        S_EXP: if (exp_go) begin
          sleep_q[head_i] <= 1'b0;
          head_q <= head_nx;
          rv_q   <= 1'b1;
          last_q <= exp_last;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (q_valid_i) begin
        cmd_q   <= q_cmd_i;
        rem_q   <= q_cmd_i.delay;
        cur_q   <= head_q;
        bef_q   <= dlst_pkg::NilLink;
        guard_q <= '0;
        cnt_q   <= '0;
        if (q_cmd_i.req == dlst_pkg::REQ_TICK && !head_q[IW] && head_delta != '0)
          delta_q[head_i] <= head_delta - W'(1);
      end
      S_WALK: begin
        tout_q <= id; exp_q <= 1'b0; st_q <= dlst_pkg::ST_ADD_IGN;
        if (!sleep_q[id] && !cur_q[IW] && guard_q != (IW+1)'(N)) begin
          if (cur_delta > rem_q) begin
            delta_q[cur_i] <= cur_delta - rem_q;
          end else begin
            rem_q   <= rem_q - cur_delta;
            bef_q   <= cur_q;
            cur_q   <= next_q[cur_i];
            guard_q <= guard_q + (IW+1)'(1);
          end
        end
      end
      S_LINK: begin
        tout_q <= id; exp_q <= 1'b0; st_q <= dlst_pkg::ST_OK;
        delta_q[id] <= rem_q;
        prev_q[id]  <= bef_q;
        next_q[id]  <= cur_q[IW] ? dlst_pkg::NilLink : cur_q;
        if (!bef_q[IW]) next_q[bef_q[IW-1:0]] <= LW'(id);
        if (!cur_q[IW]) prev_q[cur_i] <= LW'(id);
      end
      S_REM: begin
        tout_q <= id; exp_q <= 1'b0;
        st_q <= sleep_q[id] ? dlst_pkg::ST_OK : dlst_pkg::ST_REM_IGN;
        if (sleep_q[id]) begin
          if (!next_q[id][IW]) begin
            delta_q[next_q[id][IW-1:0]] <= sum[W] ? {W{1'b1}} : sum[W-1:0];
            prev_q[next_q[id][IW-1:0]]  <= prev_q[id];
          end
          if (!prev_q[id][IW]) next_q[prev_q[id][IW-1:0]] <= next_q[id];
        end
      end
      S_EXP: if (exp_go) begin
        tout_q <= head_i; exp_q <= 1'b1; st_q <= dlst_pkg::ST_OK;
        cnt_q  <= cnt_q + (IW+1)'(1);
        if (!head_nx[IW]) prev_q[head_nx[IW-1:0]] <= dlst_pkg::NilLink;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/dlst_outq.sv
`default_nettype none
module dlst_outq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [3:0]  task_i,
  input  wire logic        exp_i,
  input  wire logic [1:0]  status_i,
  input  wire logic        last_i,
  output logic             valid_o,
  output logic [3:0]       task_o,
  output logic             exp_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  // Output register stage: each result leaves from a flop for one cycle.
  logic       v_q;
  logic [3:0] t_q;
  logic       e_q, l_q;
  logic [1:0] s_q;

  assign valid_o  = v_q;
  assign task_o   = t_q;
  assign exp_o    = e_q;
  assign status_o = s_q;
  assign last_o   = l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      t_q <= task_i; e_q <= exp_i; s_q <= status_i; l_q <= last_i;
    end
  end

endmodule
`default_nettype wire

### rtl/delta_list_sleep_timer.sv
`default_nettype none
// Channel | direction | handshake       | payload
// request | in        | start & !busy   | req_type_i, task_id_i, delay_ticks_i
// result  | out       | done_o strobe   | task_out_o, expired_o, status_o, last_o
//
// List unit: an add walks past the entries ahead of it before linking; a tick gives
// one result per expired entry; remove and ignored add give one result each.
// Each result shows on done_o in the cycle after the list unit produces it.
// A two-entry command queue keeps start accepted while the list unit works;
// busy is high only while both entries are full.
// Reset clears the queue, the sleeping flags and the head; deltas and links need none.
// Results cannot be stalled: each appears for one cycle on done_o.
module delta_list_sleep_timer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [3:0]  task_id_i,
  input  wire logic [31:0] delay_ticks_i,
  output logic             done_o,
  output logic [3:0]       task_out_o,
  output logic             expired_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  dlst_pkg::cmd_t q_cmd;
  logic q_valid, q_pop;
  logic rv, rexp, rlast;
  logic [3:0] rtask;
  logic [1:0] rst_s;

  dlst_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_type_i, .task_id_i, .delay_ticks_i,
    .busy_o(busy), .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  // list unit marks last itself, also at the end of a tick drain
  dlst_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .res_valid_o(rv), .task_out_o(rtask), .expired_o(rexp), .status_o(rst_s),
    .last_o(rlast)
  );

  dlst_outq u_outq (
    .clk_i, .rst_ni, .valid_i(rv),
    .task_i(rtask), .exp_i(rexp), .status_i(rst_s), .last_i(rlast),
    .valid_o(done_o), .task_o(task_out_o), .exp_o(expired_o), .status_o(status_o),
    .last_o(last_o)
  );

endmodule
`default_nettype wire
